// ----- rtl/stdiff_pkg.sv -----
// ============================================================================
// stdiff_pkg
// Shared types, field widths and codes for the snapshot table diff block.
// ============================================================================
`default_nettype none

package stdiff_pkg;

    // Default sizing, handed to the top level as parameter defaults
    localparam int CHANNELS_DEF        = 2;
    localparam int IDS_PER_CHANNEL_DEF = 2048;
    localparam int MAX_PAGE_DEF        = 64;

    // Fixed field widths
    localparam int PAYLOAD_BYTES = 8;
    localparam int BYTE_W        = 8;
    localparam int PAYLOAD_W     = PAYLOAD_BYTES * BYTE_W;
    localparam int LEN_W         = 4;
    localparam int ID_W          = 11;
    localparam int SKIP_W        = 12;
    localparam int CAP_W         = 7;
    localparam int KIND_W        = 2;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_DIFF  = 1'b1;

    // Store select
    localparam logic SLOT_A = 1'b0;
    localparam logic SLOT_B = 1'b1;

    // Difference kinds
    localparam logic [KIND_W-1:0] KIND_ADDED   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHANGED = 2'd2;

    typedef struct packed {
        logic                 operation;
        logic                 slot;
        logic                 channel;
        logic [ID_W-1:0]      frame_id;
        logic                 present;
        logic [LEN_W-1:0]     length_code;
        logic [PAYLOAD_W-1:0] payload;
        logic [SKIP_W-1:0]    skip_count;
        logic [CAP_W-1:0]     page_cap;
    } cmd_t;

    typedef struct packed {
        logic                 is_record;
        logic                 diff_channel;
        logic [ID_W-1:0]      diff_id;
        logic [KIND_W-1:0]    kind;
        logic [LEN_W-1:0]     length_a;
        logic [LEN_W-1:0]     length_b;
        logic [PAYLOAD_W-1:0] bytes_a;
        logic [PAYLOAD_W-1:0] bytes_b;
        logic                 last;
    } diff_t;

    // One stored snapshot entry
    typedef struct packed {
        logic                 present;
        logic [LEN_W-1:0]     length;
        logic [PAYLOAD_W-1:0] bytes;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ----- rtl/stdiff_chan_if.sv -----
// ============================================================================
// stdiff_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ============================================================================
`default_nettype none

interface stdiff_chan_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

`default_nettype wire

// ----- rtl/stdiff_ram.sv -----
// ============================================================================
// stdiff_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
`default_nettype none

module stdiff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output      logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/snapshot_table_diff.sv -----
// ============================================================================
// snapshot_table_diff
// Two snapshot stores with record writes and a paged, entry-by-entry diff.
// ============================================================================
// Usage: after reset the block sweeps both stores to zero, one entry per
// cycle, through all CHANNELS*IDS_PER_CHANNEL entries (4096 with the
// defaults); cmd is not ready during that sweep. Writes can then follow back
// to back. A diff item occupies the block until its last result item is
// loaded into the output register: the scan reads one entry per cycle from the
// single read port of each store RAM unless stalled, which happens while a new
// record meets a held pending record, a full output register and diff.ready
// low; it covers every entry unless page_cap is reached early. The result stream
// always ends with an item that has last set; a diff with nothing to report
// returns a single terminator, zero apart from last, with is_record clear.
// ============================================================================
`default_nettype none

module snapshot_table_diff #(
    parameter int CHANNELS        = stdiff_pkg::CHANNELS_DEF,
    parameter int IDS_PER_CHANNEL = stdiff_pkg::IDS_PER_CHANNEL_DEF,
    parameter int MAX_PAGE        = stdiff_pkg::MAX_PAGE_DEF
) (
    input wire logic    clk,
    input wire logic    rst_n,
    stdiff_chan_if.sink   cmd,
    stdiff_chan_if.source diff
);

    // ------------------------------------------------------------------------
    // Sizing
    // ------------------------------------------------------------------------
    localparam int ENTRIES = CHANNELS * IDS_PER_CHANNEL;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDW     = (IDS_PER_CHANNEL > 1) ? $clog2(IDS_PER_CHANNEL) : 1;
    localparam int CAP_W   = stdiff_pkg::CAP_W;
    localparam int SKIP_W  = stdiff_pkg::SKIP_W;

    localparam logic [AW-1:0]    LAST_ADDR = AW'(ENTRIES - 1);
    localparam logic [IDW-1:0]   LAST_ID   = IDW'(IDS_PER_CHANNEL - 1);
    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(MAX_PAGE);

    // Sequencer states
    localparam logic [1:0] ST_CLEAR = 2'd0;   // zero sweep after reset
    localparam logic [1:0] ST_IDLE  = 2'd1;   // take writes and diff requests
    localparam logic [1:0] ST_SCAN  = 2'd2;   // walk the entries
    localparam logic [1:0] ST_FLUSH = 2'd3;   // hand out the final item

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    logic [1:0]        state_reg,        state_next;
    logic [AW-1:0]     addr_reg,         addr_next;      // sweep write / scan read address
    logic [CW-1:0]     ch_reg,           ch_next;        // channel of addr_reg
    logic [IDW-1:0]    id_reg,           id_next;        // identifier of addr_reg
    logic              more_reg,         more_next;      // entries left to read
    logic              d_valid_reg,      d_valid_next;   // RAM read data is live
    logic [CW-1:0]     d_ch_reg,         d_ch_next;
    logic [IDW-1:0]    d_id_reg,         d_id_next;
    logic [SKIP_W-1:0] skip_reg,         skip_next;
    logic [CAP_W-1:0]  cap_reg,          cap_next;
    logic [SKIP_W-1:0] skipped_reg,      skipped_next;
    logic [CAP_W-1:0]  taken_reg,        taken_next;     // records taken so far
    logic              pend_valid_reg,   pend_valid_next;
    stdiff_pkg::diff_t pend_reg,         pend_next;      // held until its successor is known
    logic              out_valid_reg,    out_valid_next;
    stdiff_pkg::diff_t out_reg,          out_next;

    // ------------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------------
    logic cmd_fire;
    logic out_free;

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign cmd_fire   = cmd.valid && cmd.ready;
    assign out_free   = !out_valid_reg || diff.ready;
    assign diff.valid = out_valid_reg;
    assign diff.data  = out_reg;

    // ------------------------------------------------------------------------
    // Store RAMs
    // ------------------------------------------------------------------------
    logic                          wr_in_range;
    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 waddr;
    stdiff_pkg::entry_t            wr_entry;
    logic [stdiff_pkg::ENTRY_W-1:0] wdata;
    logic                          is_write;
    logic                          we_a;
    logic                          we_b;
    logic                          re;
    logic [stdiff_pkg::ENTRY_W-1:0] rdata_a;
    logic [stdiff_pkg::ENTRY_W-1:0] rdata_b;
    stdiff_pkg::entry_t            ent_a;
    stdiff_pkg::entry_t            ent_b;

    assign wr_in_range = (32'(cmd.data.channel) < CHANNELS)
                      && (32'(cmd.data.frame_id) < IDS_PER_CHANNEL);
    assign wr_addr     = AW'(32'(cmd.data.channel) * IDS_PER_CHANNEL
                           + 32'(cmd.data.frame_id));
    assign wr_entry    = '{present: cmd.data.present,
                           length:  cmd.data.length_code,
                           bytes:   cmd.data.payload};

    assign is_write = cmd_fire && (cmd.data.operation == stdiff_pkg::OP_WRITE)
                   && wr_in_range;

    // Clear sweep writes zero to both stores at the sweep address
    assign we_a  = (state_reg == ST_CLEAR)
                || (is_write && (cmd.data.slot == stdiff_pkg::SLOT_A));
    assign we_b  = (state_reg == ST_CLEAR)
                || (is_write && (cmd.data.slot == stdiff_pkg::SLOT_B));
    assign waddr = (state_reg == ST_CLEAR) ? addr_reg : wr_addr;
    assign wdata = (state_reg == ST_CLEAR) ? '0 : wr_entry;

    stdiff_ram #(
        .WIDTH (stdiff_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (addr_reg),
        .rdata (rdata_a)
    );

    stdiff_ram #(
        .WIDTH (stdiff_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (addr_reg),
        .rdata (rdata_b)
    );

    assign ent_a = rdata_a;
    assign ent_b = rdata_b;

    // ------------------------------------------------------------------------
    // Entry compare: the one shared compare unit, fed, unless stalled, one entry per cycle
    // ------------------------------------------------------------------------
    logic                               is_diff;
    logic [stdiff_pkg::KIND_W-1:0]      kind;
    logic                               d_emit;
    logic                               stall;
    logic [CAP_W-1:0]                   cap_in;
    logic [CAP_W-1:0]                   taken_inc;
    stdiff_pkg::diff_t                  cand;
    stdiff_pkg::diff_t                  term;

    always_comb
    begin
        is_diff = 1'b1;
        kind    = stdiff_pkg::KIND_CHANGED;
        if (!ent_a.present && ent_b.present)
        begin
            kind = stdiff_pkg::KIND_ADDED;
        end
        else if (ent_a.present && !ent_b.present)
        begin
            kind = stdiff_pkg::KIND_REMOVED;
        end
        else if (ent_a.present && ent_b.present
                 && ((ent_a.length != ent_b.length) || (ent_a.bytes != ent_b.bytes)))
        begin
            kind = stdiff_pkg::KIND_CHANGED;
        end
        else
        begin
            is_diff = 1'b0;
        end
    end

    // Only differences past the skip window are taken
    assign d_emit    = d_valid_reg && is_diff && (skipped_reg == skip_reg);
    // A new record must push the pending one out; wait for room
    assign stall     = d_emit && pend_valid_reg && !out_free;
    assign re        = (state_reg == ST_SCAN) && !stall && more_reg;
    assign cap_in    = (cmd.data.page_cap > CAP_MAX) ? CAP_MAX : cmd.data.page_cap;
    assign taken_inc = taken_reg + 1'b1;

    assign cand = '{is_record:    1'b1,
                    diff_channel: d_ch_reg[0],
                    diff_id:      stdiff_pkg::ID_W'(d_id_reg),
                    kind:         kind,
                    length_a:     ent_a.length,
                    length_b:     ent_b.length,
                    bytes_a:      ent_a.bytes,
                    bytes_b:      ent_b.bytes,
                    last:         1'b0};

    // Empty terminator: everything zero except last
    assign term = '{is_record:    1'b0,
                    diff_channel: 1'b0,
                    diff_id:      '0,
                    kind:         stdiff_pkg::KIND_ADDED,
                    length_a:     '0,
                    length_b:     '0,
                    bytes_a:      '0,
                    bytes_b:      '0,
                    last:         1'b1};

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        ch_next         = ch_reg;
        id_next         = id_reg;
        more_next       = more_reg;
        d_valid_next    = d_valid_reg;
        d_ch_next       = d_ch_reg;
        d_id_next       = d_id_reg;
        skip_next       = skip_reg;
        cap_next        = cap_reg;
        skipped_next    = skipped_reg;
        taken_next      = taken_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !diff.ready;
        out_next        = out_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (cmd_fire && (cmd.data.operation == stdiff_pkg::OP_DIFF))
                begin
                    skip_next       = cmd.data.skip_count;
                    cap_next        = cap_in;
                    skipped_next    = '0;
                    taken_next      = '0;
                    pend_valid_next = 1'b0;
                    d_valid_next    = 1'b0;
                    addr_next       = '0;
                    ch_next         = '0;
                    id_next         = '0;
                    more_next       = 1'b1;
                    state_next      = (cap_in == '0) ? ST_FLUSH : ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (!stall)
                begin
                    // Count off skipped differences
                    if (d_valid_reg && is_diff && !d_emit)
                    begin
                        skipped_next = skipped_reg + 1'b1;
                    end

                    // Take a record; the previous one is known not to be last
                    if (d_emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = cand;
                        taken_next      = taken_inc;
                    end

                    // Advance the read side
                    d_valid_next = more_reg;
                    d_ch_next    = ch_reg;
                    d_id_next    = id_reg;
                    if (more_reg)
                    begin
                        if (addr_reg == LAST_ADDR)
                        begin
                            more_next = 1'b0;
                        end
                        else
                        begin
                            addr_next = addr_reg + 1'b1;
                        end
                        if (id_reg == LAST_ID)
                        begin
                            id_next = '0;
                            ch_next = ch_reg + 1'b1;
                        end
                        else
                        begin
                            id_next = id_reg + 1'b1;
                        end
                    end

                    // Stop on a full page or at the end of the table
                    if ((d_emit && (taken_inc == cap_reg)) || (!more_reg && !d_valid_reg))
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_valid_reg ? pend_reg : term;
                    out_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
                addr_next  = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            addr_reg       <= '0;
            ch_reg         <= '0;
            id_reg         <= '0;
            more_reg       <= 1'b0;
            d_valid_reg    <= 1'b0;
            skip_reg       <= '0;
            cap_reg        <= '0;
            skipped_reg    <= '0;
            taken_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            ch_reg         <= ch_next;
            id_reg         <= id_next;
            more_reg       <= more_next;
            d_valid_reg    <= d_valid_next;
            skip_reg       <= skip_next;
            cap_reg        <= cap_next;
            skipped_reg    <= skipped_next;
            taken_reg      <= taken_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        d_ch_reg <= d_ch_next;
        d_id_reg <= d_id_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_term_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (diff.valid && !diff.data.is_record) |-> diff.data.last)
        else $error("terminator item without last");

    a_idle_no_open_page: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.last) |-> (state_reg != ST_IDLE))
        else $error("diff closed without a last item");

    a_page_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (taken_reg < cap_reg))
        else $error("scan continued past the page cap");

    a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (skipped_reg <= skip_reg))
        else $error("skip counter overran the skip count");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && stall) |=>
            ((d_id_reg == $past(d_id_reg)) && d_valid_reg && pend_valid_reg))
        else $error("compare stage moved while stalled");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for snapshot_table_diff. Record writes and paged diffs
// are fed through the cmd channel, a local copy of both snapshot stores
// predicts every diff page, and each result item on the diff channel is
// checked field by field against the oldest predicted item.
// ============================================================================

module testbench;

    import stdiff_pkg::*;

    // Sizing follows the package defaults that the instance is built with
    localparam int N_CH        = CHANNELS_DEF;
    localparam int N_IDS       = IDS_PER_CHANNEL_DEF;
    localparam int PAGE_MAX    = MAX_PAGE_DEF;
    localparam int N_ENTRIES   = N_CH * N_IDS;

    // Stop filling the backlog once this many items are queued
    localparam int ITEM_TARGET = 470;

    // The post-reset clear sweep and a full scan both pass with nothing moving
    // on either channel; the limit is set well above their combined length.
    localparam int QUIET_LIMIT = 40000;

    // Cycles to keep watching for stray results once everything has arrived
    localparam int DRAIN_CYCLES = 64;

    typedef enum logic [1:0] {
        RX_OPEN,    // always ready
        RX_COIN,    // ready on a coin toss each cycle
        RX_RUNS     // mostly ready, with stall runs of random length
    } rx_mode_e;

    logic clk;
    logic rst_n;

    stdiff_chan_if #(.payload_t(cmd_t))  cmd_bus ();
    stdiff_chan_if #(.payload_t(diff_t)) diff_bus ();

    snapshot_table_diff uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .diff  (diff_bus)
    );

    // Local copy of both stores, updated in acceptance order
    entry_t snap_a [N_ENTRIES];
    entry_t snap_b [N_ENTRIES];

    cmd_t  cmd_backlog[$];      // items waiting to be presented
    diff_t expected_diffs[$];   // predicted result items, oldest first

    int          cmd_total;
    int          cmds_taken;
    int          mismatches;
    int          results_seen;
    int          quiet_cycles;

    // Sender state
    cmd_t cmd_cur;
    bit   cmd_held;
    bit   cmd_taken;
    int   burst_left;
    int   gap_left;

    // Receiver state
    rx_mode_e rx_mode;
    int       mode_left;
    int       stall_run;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Item builders. Fields that the operation ignores get random values so
    // that the block is shown not to care about them.
    // ------------------------------------------------------------------------
    function automatic logic [PAYLOAD_W-1:0] any_bytes();
        return {$urandom, $urandom};
    endfunction

    function automatic cmd_t write_item(logic sl, logic ch, logic [ID_W-1:0] id,
                                        logic pres, logic [LEN_W-1:0] len,
                                        logic [PAYLOAD_W-1:0] bytes_in);
        cmd_t c;
        c.operation   = OP_WRITE;
        c.slot        = sl;
        c.channel     = ch;
        c.frame_id    = id;
        c.present     = pres;
        c.length_code = len;
        c.payload     = bytes_in;
        c.skip_count  = SKIP_W'($urandom_range(0, 4095));
        c.page_cap    = CAP_W'($urandom_range(0, 127));
        return c;
    endfunction

    function automatic cmd_t diff_item(logic [SKIP_W-1:0] skip, logic [CAP_W-1:0] cap);
        cmd_t c;
        c.operation   = OP_DIFF;
        c.slot        = 1'($urandom_range(0, 1));
        c.channel     = 1'($urandom_range(0, 1));
        c.frame_id    = ID_W'($urandom_range(0, 2047));
        c.present     = 1'($urandom_range(0, 1));
        c.length_code = LEN_W'($urandom_range(0, 15));
        c.payload     = any_bytes();
        c.skip_count  = skip;
        c.page_cap    = cap;
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: apply a write to the local stores, or scan them and queue
    // the page of difference items that a diff returns.
    // ------------------------------------------------------------------------
    function automatic void step_snapshots(cmd_t c);
        int     idx;
        int     cap;
        int     passed = 0;
        int     found  = 0;
        bit     have_held = 1'b0;
        bit     is_diff;
        entry_t ea;
        entry_t eb;
        diff_t  held;
        logic [KIND_W-1:0] k;

        if (c.operation == OP_WRITE)
        begin
            // Out-of-range slots are dropped; unreachable at the default sizes
            if (int'(c.channel) >= N_CH || int'(c.frame_id) >= N_IDS)
                return;
            idx = int'(c.channel) * N_IDS + int'(c.frame_id);
            ea.present = c.present;
            ea.length  = c.length_code;
            ea.bytes   = c.payload;
            if (c.slot == SLOT_A)
                snap_a[idx] = ea;
            else
                snap_b[idx] = ea;
            return;
        end

        cap = (int'(c.page_cap) > PAGE_MAX) ? PAGE_MAX : int'(c.page_cap);

        // Channel-major, then identifier ascending: the flat index order
        for (idx = 0; idx < N_ENTRIES && found < cap; idx++)
        begin
            ea = snap_a[idx];
            eb = snap_b[idx];
            is_diff = 1'b1;
            if (!ea.present && eb.present)
                k = KIND_ADDED;
            else if (ea.present && !eb.present)
                k = KIND_REMOVED;
            else if (ea.present && eb.present &&
                     (ea.length != eb.length || ea.bytes != eb.bytes))
                k = KIND_CHANGED;
            else
                is_diff = 1'b0;   // absent in both, or identical

            if (is_diff)
            begin
                if (passed < int'(c.skip_count))
                    passed++;
                else
                begin
                    // Hold each record back one step so the final one can be marked
                    if (have_held)
                        expected_diffs.push_back(held);
                    held.is_record    = 1'b1;
                    held.diff_channel = 1'(idx / N_IDS);
                    held.diff_id      = ID_W'(idx % N_IDS);
                    held.kind         = k;
                    held.length_a     = ea.length;
                    held.length_b     = eb.length;
                    held.bytes_a      = ea.bytes;
                    held.bytes_b      = eb.bytes;
                    held.last         = 1'b0;
                    have_held = 1'b1;
                    found++;
                end
            end
        end

        if (!have_held)
        begin
            // Nothing to emit: a single all-zero terminator with last set
            held      = '0;
            held.last = 1'b1;
        end
        else
            held.last = 1'b1;
        expected_diffs.push_back(held);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t result %0d: %s mismatch, got %h, expected %h",
                 $realtime, results_seen, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus: reset the bench state, build the whole backlog, then pulse
    // reset. The driver starts draining the backlog once reset is released.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [ID_W-1:0]      hot_ids [16];
        logic [ID_W-1:0]      id;
        logic [LEN_W-1:0]     len;
        logic [PAYLOAD_W-1:0] bytes_p;
        logic [SKIP_W-1:0]    skip;
        logic [CAP_W-1:0]     cap;
        logic                 ch;
        logic                 sl;
        logic                 pres;
        int                   pick;
        int                   twist;

        // Drive every input to a known value before the first edge
        rst_n          = 1'b0;
        cmd_bus.valid  = 1'b0;
        cmd_bus.data   = '0;
        diff_bus.ready = 1'b0;
        cmd_cur        = '0;
        cmd_held       = 1'b0;
        cmd_taken      = 1'b0;
        burst_left     = 0;
        gap_left       = 0;
        rx_mode        = RX_OPEN;
        mode_left      = 0;
        stall_run      = 0;
        cmds_taken     = 0;
        mismatches     = 0;
        results_seen   = 0;
        quiet_cycles   = 0;
        foreach (snap_a[i])
        begin
            snap_a[i] = '0;
            snap_b[i] = '0;
        end

        // --- Directed part ---
        // Empty stores: terminator only
        cmd_backlog.push_back(diff_item(12'd0, 7'd64));
        // Corner entries: first slot only in A, last slot only in B
        cmd_backlog.push_back(write_item(SLOT_A, 1'b0, 11'd0, 1'b1, 4'd15, '1));
        cmd_backlog.push_back(write_item(SLOT_B, 1'b1, 11'd2047, 1'b1, 4'd0, '0));
        // Absent in both stores with different contents: not a difference
        cmd_backlog.push_back(write_item(SLOT_A, 1'b1, 11'd5, 1'b0, 4'd9, any_bytes()));
        cmd_backlog.push_back(write_item(SLOT_B, 1'b1, 11'd5, 1'b0, 4'd3, any_bytes()));
        // Identical present entries: not a difference
        bytes_p = any_bytes();
        cmd_backlog.push_back(write_item(SLOT_A, 1'b0, 11'd100, 1'b1, 4'd8, bytes_p));
        cmd_backlog.push_back(write_item(SLOT_B, 1'b0, 11'd100, 1'b1, 4'd8, bytes_p));
        // Length code alone differs
        cmd_backlog.push_back(write_item(SLOT_A, 1'b0, 11'd101, 1'b1, 4'd8, bytes_p));
        cmd_backlog.push_back(write_item(SLOT_B, 1'b0, 11'd101, 1'b1, 4'd7, bytes_p));
        // Only the top payload bit differs
        cmd_backlog.push_back(write_item(SLOT_A, 1'b0, 11'd102, 1'b1, 4'd8, bytes_p));
        cmd_backlog.push_back(write_item(SLOT_B, 1'b0, 11'd102, 1'b1, 4'd8,
                                         bytes_p ^ {1'b1, 63'd0}));
        // Whole table: removed, changed, changed, added
        cmd_backlog.push_back(diff_item(12'd0, 7'd64));
        // Zero page cap, everything skipped: terminators
        cmd_backlog.push_back(diff_item(12'd0, 7'd0));
        cmd_backlog.push_back(diff_item(12'd4095, 7'd64));
        cmd_backlog.push_back(diff_item(12'd4, 7'd1));
        // Skip one, take two from the middle
        cmd_backlog.push_back(diff_item(12'd1, 7'd2));
        // Oversized page cap clamps to the maximum
        cmd_backlog.push_back(diff_item(12'd3, 7'd127));
        // Make the first slot match, then clear the last one
        cmd_backlog.push_back(write_item(SLOT_B, 1'b0, 11'd0, 1'b1, 4'd15, '1));
        cmd_backlog.push_back(write_item(SLOT_B, 1'b1, 11'd2047, 1'b0, 4'd15, '1));
        cmd_backlog.push_back(diff_item(12'd0, 7'd127));

        // --- Random part ---
        // Most writes land on a small set of hot slots, mostly as A/B pairs, so
        // entries flip between matching, changed, added and removed.
        for (int i = 0; i < 16; i++)
            hot_ids[i] = (i == 0) ? 11'd0 : (i == 1) ? 11'd2047 : 11'($urandom_range(0, 2047));

        while (cmd_backlog.size() < ITEM_TARGET)
        begin
            pick    = $urandom_range(0, 99);
            ch      = 1'($urandom_range(0, 1));
            sl      = 1'($urandom_range(0, 1));
            id      = ($urandom_range(0, 9) < 6) ? hot_ids[$urandom_range(0, 15)]
                                                 : 11'($urandom_range(0, 2047));
            len     = LEN_W'($urandom_range(0, 15));
            bytes_p = any_bytes();
            pres    = ($urandom_range(0, 3) != 0);

            if (pick < 7)
            begin
                case ($urandom_range(0, 9))
                    7, 8:    skip = SKIP_W'($urandom_range(0, 4095));
                    9:       skip = SKIP_W'($urandom_range(9, 200));
                    default: skip = SKIP_W'($urandom_range(0, 8));
                endcase
                case ($urandom_range(0, 19))
                    0, 1, 2: cap = 7'd0;
                    3, 4, 5: cap = CAP_W'($urandom_range(64, 127));
                    6, 7, 8: cap = CAP_W'($urandom_range(17, 63));
                    default: cap = CAP_W'($urandom_range(1, 16));
                endcase
                cmd_backlog.push_back(diff_item(skip, cap));
            end
            else if (pick < 60)
            begin
                cmd_backlog.push_back(write_item(sl, ch, id, pres, len, bytes_p));
                twist = $urandom_range(0, 3);
                case (twist)
                    1: len = len ^ 4'($urandom_range(1, 15));
                    2: bytes_p = bytes_p ^ (64'($urandom_range(1, 255)) << (8 * $urandom_range(0, 7)));
                    3: pres = ~pres;
                    default: ;
                endcase
                cmd_backlog.push_back(write_item(~sl, ch, id, pres, len, bytes_p));
            end
            else
                cmd_backlog.push_back(write_item(sl, ch, id, pres, len, bytes_p));
        end
        cmd_backlog.push_back(diff_item(12'd0, 7'd64));
        cmd_total = cmd_backlog.size();

        // Hold reset low, then release it away from the rising edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every item to go in and every predicted result to come out
        while (!(cmds_taken == cmd_total && expected_diffs.size() == 0))
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender: present items in bursts with random gaps. Once valid is up the
    // item is held until accepted; gaps only fall between items.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_cmd
        if (!rst_n)
            cmd_bus.valid <= 1'b0;
        else
        begin
            if (cmd_taken)
                cmd_held = 1'b0;
            if (!cmd_held)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (cmd_backlog.size() > 0)
                begin
                    cmd_cur  = cmd_backlog.pop_front();
                    cmd_held = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        // Start a new burst; a quarter of them follow with no gap
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            cmd_bus.valid <= cmd_held;
            cmd_bus.data  <= cmd_cur;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: switch between stall patterns at random intervals.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_ready
        logic rdy;
        if (mode_left == 0)
        begin
            case ($urandom_range(0, 2))
                0:       rx_mode = RX_OPEN;
                1:       rx_mode = RX_COIN;
                default: rx_mode = RX_RUNS;
            endcase
            mode_left = $urandom_range(32, 256);
            stall_run = 0;
        end
        else
            mode_left--;

        case (rx_mode)
            RX_OPEN: rdy = 1'b1;
            RX_COIN: rdy = 1'($urandom_range(0, 1));
            default:
            begin
                if (stall_run > 0)
                begin
                    stall_run--;
                    rdy = 1'b0;
                end
                else
                begin
                    rdy = 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        stall_run = $urandom_range(1, 20);
                end
            end
        endcase
        diff_bus.ready <= rdy;
    end

    // ------------------------------------------------------------------------
    // Monitor: on each rising edge, feed accepted items to the predictor and
    // check accepted result items against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : observe
        diff_t got;
        diff_t want;
        bit    took;
        bit    gave;

        took = rst_n && cmd_bus.valid && cmd_bus.ready;
        gave = rst_n && diff_bus.valid && diff_bus.ready;

        if (took)
        begin
            cmds_taken++;
            step_snapshots(cmd_bus.data);
        end

        if (gave)
        begin
            got = diff_bus.data;
            if (expected_diffs.size() == 0)
                report_mismatch("result with nothing expected, diff_id",
                                64'(got.diff_id), '0);
            else
            begin
                want = expected_diffs.pop_front();
                if (got.is_record !== want.is_record)
                    report_mismatch("is_record", 64'(got.is_record), 64'(want.is_record));
                if (got.diff_channel !== want.diff_channel)
                    report_mismatch("diff_channel", 64'(got.diff_channel),
                                    64'(want.diff_channel));
                if (got.diff_id !== want.diff_id)
                    report_mismatch("diff_id", 64'(got.diff_id), 64'(want.diff_id));
                if (got.kind !== want.kind)
                    report_mismatch("kind", 64'(got.kind), 64'(want.kind));
                if (got.length_a !== want.length_a)
                    report_mismatch("length_a", 64'(got.length_a), 64'(want.length_a));
                if (got.length_b !== want.length_b)
                    report_mismatch("length_b", 64'(got.length_b), 64'(want.length_b));
                if (got.bytes_a !== want.bytes_a)
                    report_mismatch("bytes_a", got.bytes_a, want.bytes_a);
                if (got.bytes_b !== want.bytes_b)
                    report_mismatch("bytes_b", got.bytes_b, want.bytes_b);
                if (got.last !== want.last)
                    report_mismatch("last", 64'(got.last), 64'(want.last));
            end
            results_seen++;
        end

        // Count cycles in which neither channel moves
        if (took || gave)
            quiet_cycles = 0;
        else
            quiet_cycles++;

        cmd_taken <= took;
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if nothing has moved for too long.
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge clk);
        $display("%0t no item moved for %0d cycles", $realtime, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/stdiff_pkg.sv
rtl/stdiff_chan_if.sv
rtl/stdiff_ram.sv
rtl/snapshot_table_diff.sv
test/testbench.sv
